/* sv/cdf_pkg.sv */
// Shared types and constants for the chunked transmission deframer.
`timescale 1ns / 1ps
`default_nettype none

package cdf_pkg;

   localparam logic [31:0] SIG_BIG    = 32'h0102_0304;
   localparam logic [31:0] SIG_LITTLE = 32'h0403_0201;
   localparam logic [31:0] LEN_END    = 32'hFFFF_FFFF;

   localparam logic [2:0] PHASE_SIG_LAST = 3'd3;
   localparam logic [2:0] PHASE_LEN_BASE = 3'd4;
   localparam logic [2:0] PHASE_LEN_LAST = 3'd7;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_END     = 2'd2,
      KIND_BADSIG  = 2'd3
   } cdf_kind_type;

   typedef struct packed {
      logic        active;
      logic [2:0]  phase;
      logic [31:0] word;
      logic        little;
      logic [31:0] remaining;
   } cdf_state_type;

   typedef struct packed {
      logic         emit;
      cdf_kind_type kind;
      logic [7:0]   data;
      logic         last;
   } cdf_result_type;

   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

`default_nettype wire

/* sv/cdf_ifs.sv */
// Handshake channel interfaces for the deframer input and result streams.
`timescale 1ns / 1ps
`default_nettype none

interface cdf_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] byte_in;

   modport source (output valid, output func, output byte_in, input ready);
   modport sink   (input valid, input func, input byte_in, output ready);
endinterface

interface cdf_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_out;
   logic       chunk_last;

   modport source (output valid, output kind, output data_out, output chunk_last,
                   input ready);
   modport sink   (input valid, input kind, input data_out, input chunk_last,
                   output ready);
endinterface

`default_nettype wire

/* sv/chunked_transmission_deframer.sv */
// Top level of the chunked transmission deframer.
// Path: an accepted byte is captured in the input register, and its result is
//   then captured in the result register, from which it is presented.
// Throughput: one byte per cycle while the result channel is not stalled; the
//   per-byte shift, compare and length decrement all fit between the input register and the result register.
// Reset (synchronous, active high): idle, no transmission armed, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module chunked_transmission_deframer
   import cdf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   cdf_req_if.sink          req_ch,
   cdf_rsp_if.source        rsp_ch
);

   // input stage
   logic           in_valid_ff, in_valid_in;
   logic           in_func_ff;
   logic [7:0]     in_byte_ff;

   // deframer state
   cdf_state_type  state_ff, state_in;

   // result stage
   logic           out_valid_ff, out_valid_in;
   cdf_kind_type   out_kind_ff;
   logic [7:0]     out_data_ff;
   logic           out_last_ff;

   cdf_result_type result;
   logic           advance;
   logic           req_take;

   // an item in the input stage moves on when the result slot is free or draining
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || advance;

   cdf_step u_step (
      .state_cur (state_ff),
      .func      (in_func_ff),
      .byte_in   (in_byte_ff),
      .state_nxt (state_in),
      .result    (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = result.emit;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff <= req_ch.func;
         in_byte_ff <= req_ch.byte_in;
      end
      if (advance && result.emit) begin
         out_kind_ff <= result.kind;
         out_data_ff <= result.data;
         out_last_ff <= result.last;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.kind       = out_kind_ff;
   assign rsp_ch.data_out   = out_data_ff;
   assign rsp_ch.chunk_last = out_last_ff;

   // idle block always sits at the start of the signature
   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      !state_ff.active |-> state_ff.phase == 3'd0)
      else $error("idle with nonzero header phase");

   // payload is only counted down while a chunk body is being passed
   a_rem_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff.remaining != 32'd0 |-> state_ff.active && state_ff.phase == PHASE_LEN_BASE)
      else $error("payload count outside chunk body");

   // an emitted result is always presented in the next cycle
   a_emit_seen: assert property (@(posedge clock) disable iff (reset)
      advance && result.emit |=> out_valid_ff)
      else $error("result lost");

   // a stalled input item never lets the state move
   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without an item");

endmodule

`default_nettype wire

/* sv/cdf_step.sv */
// Next-state and result logic for one received byte.
`timescale 1ns / 1ps
`default_nettype none

module cdf_step
   import cdf_pkg::*;
(
   input  cdf_state_type  state_cur,
   input  logic           func,
   input  logic [7:0]     byte_in,
   output cdf_state_type  state_nxt,
   output cdf_result_type result
);

   logic [31:0] shifted;
   logic [2:0]  phase_inc;
   logic [31:0] len;

   assign shifted   = {state_cur.word[23:0], byte_in};
   assign phase_inc = state_cur.phase + 3'd1;
   assign len       = state_cur.little ? swap32(shifted) : shifted;

   always_comb begin
      state_nxt = state_cur;
      result    = '{emit: 1'b0, kind: KIND_PAYLOAD, data: 8'd0, last: 1'b0};
      if (func) begin
         state_nxt.active    = 1'b1;
         state_nxt.phase     = 3'd0;
         state_nxt.word      = 32'd0;
         state_nxt.remaining = 32'd0;
      end else if (state_cur.active) begin
         if (!state_cur.phase[2]) begin
            // signature bytes
            state_nxt.word  = shifted;
            state_nxt.phase = phase_inc;
            if (state_cur.phase == PHASE_SIG_LAST) begin
               if (shifted == SIG_BIG || shifted == SIG_LITTLE) begin
                  state_nxt.little    = (shifted == SIG_LITTLE);
                  state_nxt.word      = 32'd0;
                  state_nxt.remaining = 32'd0;
               end else begin
                  state_nxt.active = 1'b0;
                  state_nxt.phase  = 3'd0;
                  result.emit      = 1'b1;
                  result.kind      = KIND_BADSIG;
               end
            end
         end else if (state_cur.remaining != 32'd0) begin
            state_nxt.remaining = state_cur.remaining - 32'd1;
            result.emit = 1'b1;
            result.kind = KIND_PAYLOAD;
            result.data = byte_in;
            result.last = (state_cur.remaining == 32'd1);
         end else begin
            // length bytes
            state_nxt.word  = shifted;
            state_nxt.phase = phase_inc;
            if (state_cur.phase == PHASE_LEN_LAST) begin
               state_nxt.phase = PHASE_LEN_BASE;
               state_nxt.word  = 32'd0;
               if (shifted == LEN_END) begin
                  state_nxt.active = 1'b0;
                  state_nxt.phase  = 3'd0;
                  result.emit      = 1'b1;
                  result.kind      = KIND_END;
               end else if (len == 32'd0) begin
                  result.emit = 1'b1;
                  result.kind = KIND_EMPTY;
               end else begin
                  state_nxt.remaining = len;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire
